@@ rtl/superpixel_cluster_assign_assert.svh @@
// Assertion macros used by the verification checker of the cluster assignment block.
`ifndef SUPERPIXEL_CLUSTER_ASSIGN_ASSERT_SVH
`define SUPERPIXEL_CLUSTER_ASSIGN_ASSERT_SVH

// Same-cycle implication, sampled on clock and switched off during reset.
`define SCA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("superpixel_cluster_assign: check failed");

// Next-cycle implication, sampled on clock and switched off during reset.
`define SCA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("superpixel_cluster_assign: check failed");

`endif

@@ rtl/sca_pkg.sv @@
// Types, codes and constants shared by the cluster assignment block and its checker.
package sca_pkg;

   // Default sizes of the centre table and the pixel store.
   localparam int DEFAULT_MAX_WIDTH   = 256;
   localparam int DEFAULT_MAX_HEIGHT  = 256;
   localparam int DEFAULT_MAX_CENTERS = 512;

   // Operation codes carried by req_opcode.
   localparam logic [1:0] OP_LOAD_CENTRE = 2'd0;
   localparam logic [1:0] OP_COMPARE     = 2'd1;
   localparam logic [1:0] OP_READ        = 2'd2;
   localparam logic [1:0] OP_CLEAR       = 2'd3;

   // Distance codes: all ones means no distance yet, one below is the saturation value.
   localparam logic [31:0] DIST_NONE = 32'hFFFF_FFFF;
   localparam logic [31:0] DIST_SAT  = 32'hFFFF_FFFE;

   // Register file: word index taken from paddr bit 2.
   localparam int         CSR_AW                 = 3;
   localparam logic       CSR_IDX_IMAGE_WIDTH    = 1'b0;
   localparam logic       CSR_IDX_SPATIAL_WEIGHT = 1'b1;
   localparam logic [8:0]  IMAGE_WIDTH_RESET     = 9'd256;
   localparam logic [15:0] SPATIAL_WEIGHT_RESET  = 16'd256;

   // One entry of the centre table.
   typedef struct packed {
      logic [10:0]        l;
      logic signed [11:0] a;
      logic signed [11:0] b;
      logic [7:0]         x;
      logic [7:0]         y;
   } centre_type;

   // One entry of the pixel store.
   typedef struct packed {
      logic [31:0] distance;
      logic [8:0]  label;
      logic        valid;
   } pixel_type;

endpackage

@@ rtl/superpixel_cluster_assign.sv @@
// SLIC assignment step: centre table, per-pixel best distance store and compare datapath.
//
// The block holds a centre table of MAX_CENTERS entries and a pixel store of
// MAX_WIDTH*MAX_HEIGHT entries, both single-port synchronous memories. Each
// transaction (load centre, compare pixel, read pixel, clear pixel) gives one
// result. A transaction passes through five steps: acceptance, pixel address
// multiply and centre-table read, squaring of the differences with the pixel
// store read, the spatial weight multiply, and the final sum, saturation,
// compare and write-back. The next transaction is accepted only once the last
// has left the final step; the read-modify-write of the pixel store finishes
// before the next transaction reads it, so no forwarding is needed. A finished
// result waits in the output register while the next transaction is accepted;
// it stalls only the final step if it is not taken in time. Neither memory is
// cleared after reset: centres must be loaded and pixels cleared before use.
module superpixel_cluster_assign #(
   parameter int MAX_WIDTH   = sca_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT  = sca_pkg::DEFAULT_MAX_HEIGHT,
   parameter int MAX_CENTERS = sca_pkg::DEFAULT_MAX_CENTERS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [8:0]                req_center_index,
   input  logic [7:0]                req_pos_col,
   input  logic [7:0]                req_pos_row,
   input  logic [10:0]               req_color_l,
   input  logic signed [11:0]        req_color_a,
   input  logic signed [11:0]        req_color_b,
   // Result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [8:0]                rsp_pixel_label,
   output logic                      rsp_label_valid,
   output logic [31:0]               rsp_best_distance,
   output logic                      rsp_updated,
   // Configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [sca_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_AW    = $clog2(PIX_DEPTH);
   localparam int CEN_AW    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADDR = 5'b00010,
      ST_READ = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_CMP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [8:0]  image_width_ff, image_width_in;
   logic [15:0] spatial_weight_ff, spatial_weight_in;
   logic        csr_write;

   // Captured transaction
   logic [1:0]         op_ff;
   logic [8:0]         ci_ff;
   logic [7:0]         col_ff, row_ff;
   logic [10:0]        l_ff;
   logic signed [11:0] a_ff, b_ff;

   // Address stage
   logic [16:0]       addr_calc;
   logic [31:0]       addr_wide;
   logic [31:0]       ci_wide;
   logic              ci_ok;
   logic [PIX_AW-1:0] addr_ff;
   logic              in_image_ff;

   // Memories and their registered read data
   sca_pkg::centre_type cen_mem [0:MAX_CENTERS-1];
   sca_pkg::pixel_type  pix_mem [0:PIX_DEPTH-1];
   sca_pkg::centre_type cen_rd_ff;
   sca_pkg::pixel_type  pix_rd_ff;

   // Squaring stage
   logic signed [11:0] dl;
   logic signed [12:0] da, db;
   logic signed [8:0]  dx, dy;
   logic signed [23:0] dl_sq;
   logic signed [25:0] da_sq, db_sq;
   logic signed [17:0] dx_sq, dy_sq;
   logic [21:0]        sq_l_ff;
   logic [23:0]        sq_a_ff, sq_b_ff;
   logic [15:0]        sq_x_ff, sq_y_ff;

   // Weighting and compare stages
   logic [16:0] ds;
   logic [25:0] dc_ff, dc_in;
   logic [32:0] prod_ff, prod_in;
   logic [33:0] total;
   logic [31:0] dist_sat;
   logic        closer;
   logic        advance;

   sca_pkg::pixel_type pix_wr;
   logic               pix_we;
   logic               cen_we;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_label_ff;
   logic        rsp_lvalid_ff;
   logic [31:0] rsp_dist_ff;
   logic        rsp_upd_ff;
   logic [8:0]  res_label;
   logic        res_lvalid;
   logic [31:0] res_dist;
   logic        res_upd;

   // Configuration writes are decoded on the word index alone.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      image_width_in    = image_width_ff;
      spatial_weight_in = spatial_weight_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            sca_pkg::CSR_IDX_IMAGE_WIDTH:    image_width_in    = csr_pwdata[8:0];
            sca_pkg::CSR_IDX_SPATIAL_WEIGHT: spatial_weight_in = csr_pwdata[15:0];
            default:                         image_width_in    = image_width_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[2])
         sca_pkg::CSR_IDX_IMAGE_WIDTH:    csr_prdata = 32'(image_width_ff);
         sca_pkg::CSR_IDX_SPATIAL_WEIGHT: csr_prdata = 32'(spatial_weight_ff);
         default:                         csr_prdata = 32'd0;
      endcase
   end

   // The block takes a transaction only when no other is in progress.
   assign req_ready = (state_ff == ST_IDLE);
   assign advance   = (state_ff == ST_CMP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = (req_valid && req_ready) ? ST_ADDR : ST_IDLE;
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_CMP;
         ST_CMP:  state_in = advance ? ST_IDLE : ST_CMP;
         default: state_in = ST_IDLE;
      endcase
   end

   // Capture the transaction fields on acceptance.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_opcode;
         ci_ff  <= req_center_index;
         col_ff <= req_pos_col;
         row_ff <= req_pos_row;
         l_ff   <= req_color_l;
         a_ff   <= req_color_a;
         b_ff   <= req_color_b;
      end
   end

   // Pixel address and range checks.
   assign addr_calc = 17'(row_ff) * 17'(image_width_ff) + 17'(col_ff);
   assign addr_wide = 32'(addr_calc);
   assign ci_wide   = 32'(ci_ff);
   assign ci_ok     = ci_wide < 32'(MAX_CENTERS);

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         addr_ff     <= addr_wide[PIX_AW-1:0];
         in_image_ff <= ({1'b0, col_ff} < image_width_ff) && (addr_wide < 32'(PIX_DEPTH));
      end
   end

   // Centre table: read in the address step, written when a load completes.
   assign cen_we = advance && (op_ff == sca_pkg::OP_LOAD_CENTRE) && ci_ok;

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         cen_rd_ff <= cen_mem[ci_wide[CEN_AW-1:0]];
      end
      if (cen_we) begin
         cen_mem[ci_wide[CEN_AW-1:0]] <= '{l: l_ff, a: a_ff, b: b_ff, x: col_ff, y: row_ff};
      end
   end

   // Pixel store: read in the squaring step, written back in the compare step.
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         pix_rd_ff <= pix_mem[addr_ff];
      end
      if (pix_we) begin
         pix_mem[addr_ff] <= pix_wr;
      end
   end

   // Differences against the centre and their squares.
   assign dl    = $signed({1'b0, l_ff}) - $signed({1'b0, cen_rd_ff.l});
   assign da    = $signed({a_ff[11], a_ff}) - $signed({cen_rd_ff.a[11], cen_rd_ff.a});
   assign db    = $signed({b_ff[11], b_ff}) - $signed({cen_rd_ff.b[11], cen_rd_ff.b});
   assign dx    = $signed({1'b0, col_ff}) - $signed({1'b0, cen_rd_ff.x});
   assign dy    = $signed({1'b0, row_ff}) - $signed({1'b0, cen_rd_ff.y});
   assign dl_sq = dl * dl;
   assign da_sq = da * da;
   assign db_sq = db * db;
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         sq_l_ff <= dl_sq[21:0];
         sq_a_ff <= da_sq[23:0];
         sq_b_ff <= db_sq[23:0];
         sq_x_ff <= dx_sq[15:0];
         sq_y_ff <= dy_sq[15:0];
      end
   end

   // Colour sum and weighted spatial term.
   assign ds      = 17'(sq_x_ff) + 17'(sq_y_ff);
   assign dc_in   = 26'(sq_l_ff) + 26'(sq_a_ff) + 26'(sq_b_ff);
   assign prod_in = ds * spatial_weight_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         dc_ff   <= dc_in;
         prod_ff <= prod_in;
      end
   end

   // Final distance with saturation, compared against the stored best.
   assign total    = 34'(dc_ff) + 34'(prod_ff);
   assign dist_sat = (total > 34'(sca_pkg::DIST_SAT)) ? sca_pkg::DIST_SAT : total[31:0];
   assign closer   = dist_sat < pix_rd_ff.distance;

   // Result and write-back selection per operation.
   always_comb begin
      pix_we     = 1'b0;
      pix_wr     = pix_rd_ff;
      res_label  = pix_rd_ff.label;
      res_lvalid = pix_rd_ff.valid;
      res_dist   = pix_rd_ff.distance;
      res_upd    = 1'b0;
      if (op_ff == sca_pkg::OP_LOAD_CENTRE) begin
         res_label  = 9'd0;
         res_lvalid = 1'b0;
         res_dist   = 32'd0;
      end else if (!in_image_ff) begin
         res_label  = 9'd0;
         res_lvalid = 1'b0;
         res_dist   = sca_pkg::DIST_NONE;
      end else if (op_ff == sca_pkg::OP_CLEAR) begin
         pix_wr     = '{distance: sca_pkg::DIST_NONE, label: 9'd0, valid: 1'b0};
         pix_we     = advance;
         res_label  = 9'd0;
         res_lvalid = 1'b0;
         res_dist   = sca_pkg::DIST_NONE;
      end else if ((op_ff == sca_pkg::OP_COMPARE) && ci_ok && closer) begin
         pix_wr     = '{distance: dist_sat, label: ci_ff, valid: 1'b1};
         pix_we     = advance;
         res_label  = ci_ff;
         res_lvalid = 1'b1;
         res_dist   = dist_sat;
         res_upd    = 1'b1;
      end
   end

   // Output register: refilled when the compare step completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_label_ff  <= res_label;
         rsp_lvalid_ff <= res_lvalid;
         rsp_dist_ff   <= res_dist;
         rsp_upd_ff    <= res_upd;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         image_width_ff    <= sca_pkg::IMAGE_WIDTH_RESET;
         spatial_weight_ff <= sca_pkg::SPATIAL_WEIGHT_RESET;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         image_width_ff    <= image_width_in;
         spatial_weight_ff <= spatial_weight_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_label   = rsp_label_ff;
   assign rsp_label_valid   = rsp_lvalid_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_updated       = rsp_upd_ff;

endmodule

@@ rtl/sca_check.sv @@
// Port-level checker for the cluster assignment block, bound to its top level.
`include "superpixel_cluster_assign_assert.svh"

module sca_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_pixel_label,
   input logic        rsp_label_valid,
   input logic [31:0] rsp_best_distance,
   input logic        rsp_updated
);

   // A labelled pixel always carries a real, saturated distance.
   `SCA_ASSERT_IMPLY(a_label_has_dist, rsp_valid && rsp_label_valid, rsp_best_distance != sca_pkg::DIST_NONE)

   // A replaced entry always reports a valid label.
   `SCA_ASSERT_IMPLY(a_update_sets_label, rsp_valid && rsp_updated, rsp_label_valid)

   // The block works on one transaction at a time.
   `SCA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // A result that is not taken holds its payload.
   `SCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_best_distance) && $stable(rsp_pixel_label))

endmodule

bind superpixel_cluster_assign sca_check u_sca_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pixel_label   (rsp_pixel_label),
   .rsp_label_valid   (rsp_label_valid),
   .rsp_best_distance (rsp_best_distance),
   .rsp_updated       (rsp_updated)
);
